FILE: rtl/ray_box_intersect_defines.svh
// Assertion macros used by the ray box intersection top level.
`ifndef RAY_BOX_INTERSECT_DEFINES_SVH
`define RAY_BOX_INTERSECT_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define RBI_ASSERT_SAME(label, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error(msg);

// Check that a condition implies another in the next cycle.
`define RBI_ASSERT_NEXT(label, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error(msg);

`endif

FILE: rtl/rbi_pkg.sv
// Shared constants and types of the ray box intersection block.
package rbi_pkg;

    localparam int COORD_BITS = 32;
    localparam int NUM_AXES   = 3;
    localparam int SIDE_BITS  = 3 * COORD_BITS + 1;

    typedef logic [1:0] axis_t;

    typedef enum logic [1:0] {
        STATUS_MISS   = 2'd0,
        STATUS_HIT    = 2'd1,
        STATUS_INSIDE = 2'd2
    } status_t;

    typedef struct packed {
        logic  miss;
        logic  in_box;
        logic  nocand;
        axis_t win;
    } meta_t;

endpackage

FILE: rtl/rbi_query_if.sv
// Query channel: box corners, ray origin and destination.
interface rbi_query_if #(parameter int C = rbi_pkg::COORD_BITS);
    logic valid;
    logic ready;
    logic signed [C-1:0] box_min_x;
    logic signed [C-1:0] box_min_y;
    logic signed [C-1:0] box_min_z;
    logic signed [C-1:0] box_max_x;
    logic signed [C-1:0] box_max_y;
    logic signed [C-1:0] box_max_z;
    logic signed [C-1:0] origin_x;
    logic signed [C-1:0] origin_y;
    logic signed [C-1:0] origin_z;
    logic signed [C-1:0] dest_x;
    logic signed [C-1:0] dest_y;
    logic signed [C-1:0] dest_z;

    modport source (
        output valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
               origin_x, origin_y, origin_z, dest_x, dest_y, dest_z,
        input  ready
    );
    modport sink (
        input  valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
               origin_x, origin_y, origin_z, dest_x, dest_y, dest_z,
        output ready
    );
endinterface

FILE: rtl/rbi_result_if.sv
// Result channel: status and intersection point.
interface rbi_result_if #(parameter int C = rbi_pkg::COORD_BITS);
    logic valid;
    logic ready;
    rbi_pkg::status_t status;
    logic signed [C-1:0] hit_x;
    logic signed [C-1:0] hit_y;
    logic signed [C-1:0] hit_z;

    modport source (output valid, status, hit_x, hit_y, hit_z, input ready);
    modport sink (input valid, status, hit_x, hit_y, hit_z, output ready);
endinterface

FILE: rtl/rbi_lane.sv
// Per-axis slab classification and distance magnitudes.
module rbi_lane #(
    parameter int C = rbi_pkg::COORD_BITS
) (
    input  logic                clk,
    input  logic                en,
    input  logic signed [C-1:0] mn,
    input  logic signed [C-1:0] mx,
    input  logic signed [C-1:0] o,
    input  logic signed [C-1:0] de,
    output logic                cand_reg,
    output logic                miss_reg,
    output logic                outside_reg,
    output logic signed [C-1:0] plane_reg,
    output logic [C:0]          num_reg,
    output logic [C:0]          den_reg,
    output logic                dneg_reg,
    output logic signed [C-1:0] o_reg,
    output logic signed [C-1:0] mn_reg,
    output logic signed [C-1:0] mx_reg
);
    localparam int W = C + 1;

    logic                below, above, outside, miss;
    logic signed [C-1:0] plane;
    logic signed [W-1:0] dn, dd;
    logic [W-1:0]        num, den;

    always_comb
    begin
        below   = o < mn;
        above   = o > mx;
        outside = below || above;
        miss    = below ? (de < mn) : (above && (de > mx));
        plane   = below ? mn : (above ? mx : C'(0));
        dn      = W'(plane) - W'(o);
        dd      = W'(de) - W'(o);
        num     = dn[W-1] ? W'(-dn) : W'(dn);
        den     = dd[W-1] ? W'(-dd) : W'(dd);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cand_reg    <= outside && (den != '0);
            miss_reg    <= miss;
            outside_reg <= outside;
            plane_reg   <= plane;
            num_reg     <= num;
            den_reg     <= den;
            dneg_reg    <= dd[W-1];
            o_reg       <= o;
            mn_reg      <= mn;
            mx_reg      <= mx;
        end
    end
endmodule

FILE: rtl/rbi_select.sv
// Cross products, winning plane choice and numerators for the other axes.
module rbi_select #(
    parameter int C = rbi_pkg::COORD_BITS
) (
    input  logic                clk,
    input  logic [2:0]          en,
    input  logic                cand [rbi_pkg::NUM_AXES],
    input  logic                miss [rbi_pkg::NUM_AXES],
    input  logic                outside [rbi_pkg::NUM_AXES],
    input  logic signed [C-1:0] plane [rbi_pkg::NUM_AXES],
    input  logic [C:0]          num [rbi_pkg::NUM_AXES],
    input  logic [C:0]          den [rbi_pkg::NUM_AXES],
    input  logic                dneg [rbi_pkg::NUM_AXES],
    input  logic signed [C-1:0] o [rbi_pkg::NUM_AXES],
    input  logic signed [C-1:0] mn [rbi_pkg::NUM_AXES],
    input  logic signed [C-1:0] mx [rbi_pkg::NUM_AXES],
    output logic [2*C+1:0]      n_reg [rbi_pkg::NUM_AXES],
    output logic [C:0]          denw_out_reg,
    output logic [3*C:0]        side_reg [rbi_pkg::NUM_AXES],
    output rbi_pkg::meta_t      meta_out_reg,
    output logic signed [C-1:0] planew_out_reg
);
    import rbi_pkg::*;

    localparam int W  = C + 1;
    localparam int PW = 2 * W;

    // product stage
    logic [PW-1:0]       p01_reg, p10_reg, p02_reg, p20_reg, p12_reg, p21_reg;
    logic                c2_reg [NUM_AXES];
    logic                m2_reg [NUM_AXES];
    logic                out2_reg [NUM_AXES];
    logic signed [C-1:0] pl2_reg [NUM_AXES];
    logic [W-1:0]        num2_reg [NUM_AXES];
    logic [W-1:0]        den2_reg [NUM_AXES];
    logic                dn2_reg [NUM_AXES];
    logic signed [C-1:0] o2_reg [NUM_AXES];
    logic signed [C-1:0] mn2_reg [NUM_AXES];
    logic signed [C-1:0] mx2_reg [NUM_AXES];

    // choice stage
    logic [W-1:0]        numw_reg, denw_reg;
    logic signed [C-1:0] planew_reg;
    meta_t               meta_reg;
    logic [W-1:0]        den3_reg [NUM_AXES];
    logic [3*C:0]        side3_reg [NUM_AXES];

    axis_t w;
    meta_t meta_next;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            p01_reg <= num[0] * den[1];
            p10_reg <= num[1] * den[0];
            p02_reg <= num[0] * den[2];
            p20_reg <= num[2] * den[0];
            p12_reg <= num[1] * den[2];
            p21_reg <= num[2] * den[1];
            for (int i = 0; i < NUM_AXES; i++)
            begin
                c2_reg[i]   <= cand[i];
                m2_reg[i]   <= miss[i];
                out2_reg[i] <= outside[i];
                pl2_reg[i]  <= plane[i];
                num2_reg[i] <= num[i];
                den2_reg[i] <= den[i];
                dn2_reg[i]  <= dneg[i];
                o2_reg[i]   <= o[i];
                mn2_reg[i]  <= mn[i];
                mx2_reg[i]  <= mx[i];
            end
        end
    end

    always_comb
    begin
        w = 2'd0;
        if (c2_reg[1] && (!c2_reg[0] || (p01_reg < p10_reg)))
            w = 2'd1;
        if (w == 2'd0)
        begin
            if (c2_reg[2] && (!c2_reg[0] || (p02_reg < p20_reg)))
                w = 2'd2;
        end
        else
        begin
            if (c2_reg[2] && (!c2_reg[1] || (p12_reg < p21_reg)))
                w = 2'd2;
        end
        meta_next.miss   = m2_reg[0] || m2_reg[1] || m2_reg[2];
        meta_next.in_box = !(out2_reg[0] || out2_reg[1] || out2_reg[2]);
        meta_next.nocand = !c2_reg[w];
        meta_next.win    = w;
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            numw_reg   <= num2_reg[w];
            denw_reg   <= den2_reg[w];
            planew_reg <= pl2_reg[w];
            meta_reg   <= meta_next;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                den3_reg[i]  <= den2_reg[i];
                side3_reg[i] <= {dn2_reg[i], o2_reg[i], mn2_reg[i], mx2_reg[i]};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                n_reg[i]    <= numw_reg * den3_reg[i] + PW'(denw_reg >> 1);
                side_reg[i] <= side3_reg[i];
            end
            denw_out_reg   <= denw_reg;
            meta_out_reg   <= meta_reg;
            planew_out_reg <= planew_reg;
        end
    end
endmodule

FILE: rtl/rbi_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module rbi_div #(
    parameter int C  = rbi_pkg::COORD_BITS,
    parameter int SW = rbi_pkg::SIDE_BITS
) (
    input  logic              clk,
    input  logic [C+1:0]      en,
    input  logic [2*C+1:0]    num,
    input  logic [C:0]        den,
    input  logic [SW-1:0]     side,
    output logic [C+1:0]      q,
    output logic [SW-1:0]     side_out
);
    localparam int W  = C + 1;
    localparam int QW = C + 2;
    localparam int PW = 2 * W;

    logic [W-1:0]  r_reg [QW];
    logic [QW-1:0] low_reg [QW];
    logic [W-1:0]  den_reg [QW];
    logic [SW-1:0] side_reg [QW];

    for (genvar k = 0; k < QW; k++)
    begin : g_step
        logic [W-1:0]  r_in, d_in;
        logic [QW-1:0] low_in;
        logic [SW-1:0] s_in;
        logic [W:0]    t;
        logic          ge;

        if (k == 0)
        begin : g_first
            assign r_in   = W'(num[PW-1:QW]);
            assign low_in = num[QW-1:0];
            assign d_in   = den;
            assign s_in   = side;
        end
        else
        begin : g_next
            assign r_in   = r_reg[k-1];
            assign low_in = low_reg[k-1];
            assign d_in   = den_reg[k-1];
            assign s_in   = side_reg[k-1];
        end

        assign t  = {r_in, low_in[QW-1]};
        assign ge = t >= {1'b0, d_in};

        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                r_reg[k]    <= ge ? W'(t - {1'b0, d_in}) : t[W-1:0];
                low_reg[k]  <= {low_in[QW-2:0], ge};
                den_reg[k]  <= d_in;
                side_reg[k] <= s_in;
            end
        end
    end

    assign q        = low_reg[QW-1];
    assign side_out = side_reg[QW-1];
endmodule

FILE: rtl/rbi_merge.sv
// Off-plane coordinates, box check and result register.
module rbi_merge #(
    parameter int C = rbi_pkg::COORD_BITS
) (
    input  logic                clk,
    input  logic                en,
    input  rbi_pkg::meta_t      meta,
    input  logic signed [C-1:0] planew,
    input  logic [C+1:0]        q [rbi_pkg::NUM_AXES],
    input  logic [3*C:0]        side [rbi_pkg::NUM_AXES],
    output rbi_pkg::status_t    status_reg,
    output logic signed [C-1:0] hit_reg [rbi_pkg::NUM_AXES]
);
    import rbi_pkg::*;

    localparam int HW = C + 3;

    logic signed [HW-1:0] qs [NUM_AXES];
    logic signed [HW-1:0] hit [NUM_AXES];
    logic signed [C-1:0]  o [NUM_AXES];
    logic signed [C-1:0]  mn [NUM_AXES];
    logic signed [C-1:0]  mx [NUM_AXES];
    logic signed [C-1:0]  val [NUM_AXES];
    logic                 bad [NUM_AXES];
    status_t              status_next;
    logic signed [C-1:0]  hit_next [NUM_AXES];

    always_comb
    begin
        for (int j = 0; j < NUM_AXES; j++)
        begin
            mx[j]  = $signed(side[j][C-1:0]);
            mn[j]  = $signed(side[j][2*C-1:C]);
            o[j]   = $signed(side[j][3*C-1:2*C]);
            qs[j]  = $signed({1'b0, q[j]});
            hit[j] = HW'(o[j]) + (side[j][3*C] ? -qs[j] : qs[j]);
            bad[j] = (axis_t'(j) != meta.win) &&
                     ((hit[j] < HW'(mn[j])) || (hit[j] > HW'(mx[j])));
            val[j] = (axis_t'(j) == meta.win) ? planew : hit[j][C-1:0];
        end
        status_next = STATUS_MISS;
        for (int j = 0; j < NUM_AXES; j++)
            hit_next[j] = '0;
        if (!meta.miss)
        begin
            if (meta.in_box)
            begin
                status_next = STATUS_INSIDE;
                for (int j = 0; j < NUM_AXES; j++)
                    hit_next[j] = o[j];
            end
            else if (!meta.nocand && !(bad[0] || bad[1] || bad[2]))
            begin
                status_next = STATUS_HIT;
                for (int j = 0; j < NUM_AXES; j++)
                    hit_next[j] = val[j];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            status_reg <= status_next;
            for (int j = 0; j < NUM_AXES; j++)
                hit_reg[j] <= hit_next[j];
        end
    end
endmodule

FILE: rtl/ray_box_intersect.sv
// Top level of the ray against axis-aligned box intersection block.
//
//  channel   dir   payload
//  query     in    box_min/box_max/origin/dest x,y,z (signed fixed point)
//  result    out   status, hit_x, hit_y, hit_z
//
// One query per cycle while the result channel is ready; the stages are classify,
// products, plane choice, numerators, COORD_BITS + 2 divider steps, result register.
// The divider pipeline, one quotient bit per stage, sets the latency.
// Reset clears the stage valid bits only; payload registers are not reset.
// Each stage holds while the next is full and stalled; empty stages still fill.
module ray_box_intersect #(
    parameter int COORD_BITS = rbi_pkg::COORD_BITS
) (
    input  logic clk,
    input  logic rst_n,
    rbi_query_if.sink    query,
    rbi_result_if.source result
);
    import rbi_pkg::*;

    `include "ray_box_intersect_defines.svh"

    localparam int C  = COORD_BITS;
    localparam int QW = C + 2;
    localparam int SW = 3 * C + 1;
    localparam int N  = QW + 5;
    localparam int DIV_OFS = 4;

    logic [N-1:0] v_reg, v_next, en;

    always_comb
    begin
        for (int k = 0; k < N; k++)
            en[k] = result.ready || (|((~v_reg) >> k));
        for (int k = 0; k < N; k++)
        begin
            if (!en[k])
                v_next[k] = v_reg[k];
            else if (k == 0)
                v_next[k] = query.valid;
            else
                v_next[k] = v_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    assign query.ready  = en[0];
    assign result.valid = v_reg[N-1];

    logic signed [C-1:0] mn_in [NUM_AXES];
    logic signed [C-1:0] mx_in [NUM_AXES];
    logic signed [C-1:0] o_in [NUM_AXES];
    logic signed [C-1:0] de_in [NUM_AXES];

    assign mn_in = '{query.box_min_x, query.box_min_y, query.box_min_z};
    assign mx_in = '{query.box_max_x, query.box_max_y, query.box_max_z};
    assign o_in  = '{query.origin_x, query.origin_y, query.origin_z};
    assign de_in = '{query.dest_x, query.dest_y, query.dest_z};

    logic                l_cand [NUM_AXES];
    logic                l_miss [NUM_AXES];
    logic                l_out [NUM_AXES];
    logic signed [C-1:0] l_plane [NUM_AXES];
    logic [C:0]          l_num [NUM_AXES];
    logic [C:0]          l_den [NUM_AXES];
    logic                l_dneg [NUM_AXES];
    logic signed [C-1:0] l_o [NUM_AXES];
    logic signed [C-1:0] l_mn [NUM_AXES];
    logic signed [C-1:0] l_mx [NUM_AXES];

    for (genvar i = 0; i < NUM_AXES; i++)
    begin : g_lane
        rbi_lane #(.C(C)) u_lane (
            .clk         (clk),
            .en          (en[0]),
            .mn          (mn_in[i]),
            .mx          (mx_in[i]),
            .o           (o_in[i]),
            .de          (de_in[i]),
            .cand_reg    (l_cand[i]),
            .miss_reg    (l_miss[i]),
            .outside_reg (l_out[i]),
            .plane_reg   (l_plane[i]),
            .num_reg     (l_num[i]),
            .den_reg     (l_den[i]),
            .dneg_reg    (l_dneg[i]),
            .o_reg       (l_o[i]),
            .mn_reg      (l_mn[i]),
            .mx_reg      (l_mx[i])
        );
    end

    logic [2*C+1:0]      s_n [NUM_AXES];
    logic [C:0]          s_denw;
    logic [SW-1:0]       s_side [NUM_AXES];
    meta_t               s_meta;
    logic signed [C-1:0] s_planew;

    rbi_select #(.C(C)) u_select (
        .clk            (clk),
        .en             (en[3:1]),
        .cand           (l_cand),
        .miss           (l_miss),
        .outside        (l_out),
        .plane          (l_plane),
        .num            (l_num),
        .den            (l_den),
        .dneg           (l_dneg),
        .o              (l_o),
        .mn             (l_mn),
        .mx             (l_mx),
        .n_reg          (s_n),
        .denw_out_reg   (s_denw),
        .side_reg       (s_side),
        .meta_out_reg   (s_meta),
        .planew_out_reg (s_planew)
    );

    logic [QW-1:0] d_q [NUM_AXES];
    logic [SW-1:0] d_side [NUM_AXES];

    for (genvar i = 0; i < NUM_AXES; i++)
    begin : g_div
        rbi_div #(.C(C), .SW(SW)) u_div (
            .clk      (clk),
            .en       (en[DIV_OFS +: QW]),
            .num      (s_n[i]),
            .den      (s_denw),
            .side     (s_side[i]),
            .q        (d_q[i]),
            .side_out (d_side[i])
        );
    end

    meta_t               meta_reg [QW];
    logic signed [C-1:0] planew_reg [QW];

    for (genvar k = 0; k < QW; k++)
    begin : g_meta
        always_ff @(posedge clk)
        begin
            if (en[DIV_OFS + k])
            begin
                meta_reg[k]   <= (k == 0) ? s_meta : meta_reg[(k == 0) ? 0 : k - 1];
                planew_reg[k] <= (k == 0) ? s_planew : planew_reg[(k == 0) ? 0 : k - 1];
            end
        end
    end

    status_t             m_status;
    logic signed [C-1:0] m_hit [NUM_AXES];

    rbi_merge #(.C(C)) u_merge (
        .clk        (clk),
        .en         (en[N-1]),
        .meta       (meta_reg[QW-1]),
        .planew     (planew_reg[QW-1]),
        .q          (d_q),
        .side       (d_side),
        .status_reg (m_status),
        .hit_reg    (m_hit)
    );

    assign result.status = m_status;
    assign result.hit_x  = m_hit[0];
    assign result.hit_y  = m_hit[1];
    assign result.hit_z  = m_hit[2];

    `RBI_ASSERT_SAME(a_stall_full, !query.ready, &v_reg,
        "query stalled while a pipeline stage is empty")
    `RBI_ASSERT_SAME(a_miss_zero, result.valid && (result.status == STATUS_MISS),
        (result.hit_x == '0) && (result.hit_y == '0) && (result.hit_z == '0),
        "miss result with nonzero coordinates")
    `RBI_ASSERT_NEXT(a_accept_fills, query.valid && query.ready, v_reg[0],
        "accepted query not captured by the first stage")
endmodule

FILE: tb/sv/tb_ray_box_intersect.sv
// Self-checking testbench of ray_box_intersect: directed and random queries, checked in order.
module tb_ray_box_intersect;
    timeunit 1ns;
    timeprecision 1ps;

    import rbi_pkg::*;

    localparam int LATENCY     = COORD_BITS + 7;
    localparam int CYCLE_LIMIT = 400000;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct {
        coord_t mn[NUM_AXES];
        coord_t mx[NUM_AXES];
        coord_t org[NUM_AXES];
        coord_t dst[NUM_AXES];
    } ray_query_t;

    typedef struct {
        status_t status;
        coord_t  pt[NUM_AXES];
    } hit_point_t;

    logic clk;
    logic rst_n;
    int   idle_pct;
    int   stall_pct;
    int   mismatches;
    int   cycles;

    hit_point_t pending_hits[$];

    rbi_query_if  query_ch ();
    rbi_result_if result_ch ();

    ray_box_intersect DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .query  (query_ch),
        .result (result_ch)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic logic [127:0] mag(longint v);
        return v < 0 ? 128'(-v) : 128'(v);
    endfunction

    function automatic hit_point_t intersect_point(ray_query_t q);
        hit_point_t    r;
        longint        mn[NUM_AXES], mx[NUM_AXES], o[NUM_AXES], d[NUM_AXES];
        longint        plane[NUM_AXES], h[NUM_AXES];
        logic [127:0]  num[NUM_AXES], den[NUM_AXES];
        logic [127:0]  prod, quo;
        bit            cand[NUM_AXES];
        bit            in_box;
        bit            miss;
        int            w;
        longint        dj;
        r.status = STATUS_MISS;
        in_box = 1'b1;
        miss = 1'b0;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            r.pt[i] = '0;
            mn[i] = q.mn[i];
            mx[i] = q.mx[i];
            o[i] = q.org[i];
            d[i] = q.dst[i];
            cand[i] = 1'b0;
            plane[i] = 0;
            if (o[i] < mn[i])
            begin
                if (d[i] < mn[i])
                    miss = 1'b1;
                cand[i] = 1'b1;
                plane[i] = mn[i];
                in_box = 1'b0;
            end
            else if (o[i] > mx[i])
            begin
                if (d[i] > mx[i])
                    miss = 1'b1;
                cand[i] = 1'b1;
                plane[i] = mx[i];
                in_box = 1'b0;
            end
        end
        if (miss)
            return r;
        if (in_box)
        begin
            r.status = STATUS_INSIDE;
            r.pt = q.org;
            return r;
        end
        for (int i = 0; i < NUM_AXES; i++)
        begin
            num[i] = mag(plane[i] - o[i]);
            den[i] = mag(d[i] - o[i]);
            if (den[i] == 0)
                cand[i] = 1'b0;
        end
        w = 0;
        for (int i = 1; i < NUM_AXES; i++)
            if (cand[i] && (!cand[w] || num[w] * den[i] < num[i] * den[w]))
                w = i;
        if (!cand[w])
            return r;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            if (i == w)
                h[i] = plane[i];
            else
            begin
                dj = d[i] - o[i];
                prod = num[w] * mag(dj) + (den[w] >> 1);
                quo = prod / den[w];
                h[i] = dj < 0 ? o[i] - longint'(quo[63:0]) : o[i] + longint'(quo[63:0]);
                if (h[i] < mn[i] || h[i] > mx[i])
                    return r;
            end
        end
        r.status = STATUS_HIT;
        for (int i = 0; i < NUM_AXES; i++)
            r.pt[i] = h[i][COORD_BITS-1:0];
        return r;
    endfunction

    task automatic send_query(ray_query_t q);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            query_ch.valid <= 1'b0;
            @(posedge clk);
        end
        query_ch.box_min_x <= q.mn[0];
        query_ch.box_min_y <= q.mn[1];
        query_ch.box_min_z <= q.mn[2];
        query_ch.box_max_x <= q.mx[0];
        query_ch.box_max_y <= q.mx[1];
        query_ch.box_max_z <= q.mx[2];
        query_ch.origin_x  <= q.org[0];
        query_ch.origin_y  <= q.org[1];
        query_ch.origin_z  <= q.org[2];
        query_ch.dest_x    <= q.dst[0];
        query_ch.dest_y    <= q.dst[1];
        query_ch.dest_z    <= q.dst[2];
        query_ch.valid     <= 1'b1;
        do
            @(posedge clk);
        while (!query_ch.ready);
        pending_hits.push_back(intersect_point(q));
    endtask

    always @(posedge clk)
        result_ch.ready <= stall_pct == 0 || $urandom_range(99) >= stall_pct;

    always @(posedge clk)
    begin
        hit_point_t e;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_hits.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transfer: status %0d hit %0d %0d %0d",
                             result_ch.status, result_ch.hit_x, result_ch.hit_y,
                             result_ch.hit_z);
            end
            else
            begin
                e = pending_hits.pop_front();
                if (result_ch.status !== e.status || result_ch.hit_x !== e.pt[0] ||
                    result_ch.hit_y !== e.pt[1] || result_ch.hit_z !== e.pt[2])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %0d (%0d %0d %0d) got %0d (%0d %0d %0d)",
                                 e.status, e.pt[0], e.pt[1], e.pt[2], result_ch.status,
                                 result_ch.hit_x, result_ch.hit_y, result_ch.hit_z);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic ray_query_t make_query(longint mn0, longint mn1, longint mn2,
        longint mx0, longint mx1, longint mx2, longint o0, longint o1, longint o2,
        longint d0, longint d1, longint d2);
        ray_query_t q;
        q.mn  = '{mn0[31:0], mn1[31:0], mn2[31:0]};
        q.mx  = '{mx0[31:0], mx1[31:0], mx2[31:0]};
        q.org = '{o0[31:0], o1[31:0], o2[31:0]};
        q.dst = '{d0[31:0], d1[31:0], d2[31:0]};
        return q;
    endfunction

    function automatic longint pick(longint lo, longint hi);
        return lo + longint'($urandom_range(32'(hi - lo)));
    endfunction

    function automatic ray_query_t random_query();
        ray_query_t q;
        longint     s, lo, hi;
        int         kind;
        kind = $urandom_range(99);
        case ($urandom_range(2))
            0: s = 16;
            1: s = 65536;
            default: s = 1 << 28;
        endcase
        for (int i = 0; i < NUM_AXES; i++)
        begin
            if (kind < 15)
            begin
                q.mn[i] = $urandom;
                q.mx[i] = $urandom;
                q.org[i] = $urandom;
                q.dst[i] = $urandom;
            end
            else
            begin
                lo = pick(-s, s);
                hi = lo + pick(0, s);
                q.mn[i] = lo[31:0];
                q.mx[i] = hi[31:0];
                q.org[i] = 32'(pick(-3 * s, 3 * s));
                q.dst[i] = kind < 85 ? 32'(pick(lo, hi)) : 32'(pick(-3 * s, 3 * s));
            end
        end
        return q;
    endfunction

    task automatic test_directed();
        longint lo, hi;
        lo = -64'sd2147483648;
        hi = 64'sd2147483647;
        send_query(make_query(0, 0, 0, 10, 10, 10, 5, 5, 5, 20, 20, 20));
        send_query(make_query(0, 0, 0, 10, 10, 10, 0, 10, 0, -5, -5, -5));
        send_query(make_query(0, 0, 0, 10, 10, 10, -5, 5, 5, -1, 5, 5));
        send_query(make_query(0, 0, 0, 10, 10, 10, 5, 15, 5, 5, 12, 5));
        send_query(make_query(0, 0, 0, 10, 10, 10, 5, 5, -3, 5, 5, -9));
        send_query(make_query(0, 0, 0, 10, 10, 10, -5, 3, 4, 6, 7, 8));
        send_query(make_query(0, 0, 0, 10, 10, 10, 2, 20, 3, 7, 1, 6));
        send_query(make_query(0, 0, 0, 10, 10, 10, 9, 1, 30, 2, 8, 0));
        send_query(make_query(0, 0, 0, 4, 4, 4, -1, -1, 0, 3, 3, 1));
        send_query(make_query(0, 0, 0, 10, 10, 10, -2, 0, 0, 2, 1, 0));
        send_query(make_query(0, 0, 0, 10, 10, 10, -2, 5, 5, 2, 4, 4));
        send_query(make_query(0, 0, 0, 10, 10, 10, -2, 1, 3, 2, 20, 3));
        send_query(make_query(lo, lo, lo, hi, hi, hi, lo, hi, 0, hi, lo, 0));
        send_query(make_query(lo, lo, lo, hi, hi, lo, 0, 0, hi, 0, 0, lo));
        send_query(make_query(lo + 1, lo, lo, hi, hi, hi, lo, hi, lo, hi, lo, hi));
        send_query(make_query(0, lo, lo, 0, hi, hi, lo, lo, hi, hi, hi, lo));
        send_query(make_query(10, 10, 10, 0, 0, 0, 5, 5, 5, 6, 6, 6));
        send_query(make_query(0, 0, 0, 10, 10, 10, -5, -5, -5, -5, -5, -5));
        send_query(make_query(-65536, -65536, -65536, 65536, 65536, 65536,
                              -196608, 1, -1, 0, 3, -3));
        send_query(make_query(-1, -1, -1, -1, -1, -1, -7, 3, -1, 0, -2, -1));
        send_query(make_query(10, 0, 0, 0, 10, 10, 5, 5, 5, 20, 5, 5));
    endtask

    task automatic test_random(int items, int send_idle, int recv_stall);
        idle_pct = send_idle;
        stall_pct = recv_stall;
        repeat (items)
            send_query(random_query());
    endtask

    initial
    begin
        rst_n = 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        mismatches = 0;
        cycles = 0;
        query_ch.valid = 1'b0;
        query_ch.box_min_x = '0;
        query_ch.box_min_y = '0;
        query_ch.box_min_z = '0;
        query_ch.box_max_x = '0;
        query_ch.box_max_y = '0;
        query_ch.box_max_z = '0;
        query_ch.origin_x = '0;
        query_ch.origin_y = '0;
        query_ch.origin_z = '0;
        query_ch.dest_x = '0;
        query_ch.dest_y = '0;
        query_ch.dest_z = '0;
        result_ch.ready = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(290, 0, 0);
        test_random(290, 45, 0);
        test_random(290, 0, 45);
        test_random(290, 9, 9);
        query_ch.valid <= 1'b0;
        stall_pct = 0;
        while (pending_hits.size() > 0)
            @(posedge clk);
        repeat (2 * LATENCY) @(posedge clk);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

FILE: ray_box_intersect.f
+incdir+rtl
rtl/rbi_pkg.sv
rtl/rbi_query_if.sv
rtl/rbi_result_if.sv
rtl/rbi_lane.sv
rtl/rbi_select.sv
rtl/rbi_div.sv
rtl/rbi_merge.sv
rtl/ray_box_intersect.sv
tb/sv/tb_ray_box_intersect.sv
